### hdl/pdsv_pkg.sv
// Shared types and constants for the pairwise distance symmetry vote unit.
// No dependencies; every other file but pdsv_ram imports this package.
`default_nettype none

package pdsv_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int IDX_W       = 6;
  localparam int DIST_W      = 24;
  localparam int THR_W       = 23;
  localparam int PCNT_W      = 7;
  localparam int COUNT_W     = 32;
  localparam int LIMIT_W     = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 23;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PCNT_W-1:0] POINT_COUNT_RST = PCNT_W'(64);
  localparam logic [THR_W-1:0]  THRESHOLD_RST   = THR_W'(256);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_VOTE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_VOTED  = 2'd1,
    ST_REPEAT = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_VOTE = 2'd2,
    KIND_READ = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 1'b0,
    REG_THRESHOLD   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IDX_W-1:0]        index_a;
    logic [IDX_W-1:0]        index_b;
    logic [IDX_W-1:0]        index_c;
    logic [IDX_W-1:0]        index_d;
    logic [IDX_W-1:0]        index_e;
    logic [IDX_W-1:0]        index_f;
    logic signed [DIST_W-1:0] distance_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] vote_count;
  } res_t;

  // Classified request as it travels through the queue.
  typedef struct packed {
    kind_e             kind;
    logic [1:0]        status;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  c;
    logic [IDX_W-1:0]  d;
    logic [IDX_W-1:0]  e;
    logic [IDX_W-1:0]  f;
    logic [DIST_W-1:0] distance;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

`default_nettype wire

### hdl/pairwise_distance_symmetry_vote_unit.sv
// Top level of the pairwise distance symmetry vote unit; uses pdsv_pkg, pdsv_front,
// pdsv_queue and pdsv_back. The back end handles one request at a time: loads and rejected
// requests need no read, reads wait for the vote memory, and votes wait for the distance
// reads and, on a match, two counter writes; a 2-entry queue lets the front accept meanwhile.
// The receiver cannot stall. After reset busy stays high while the vote counters clear.
`default_nettype none

module pairwise_distance_symmetry_vote_unit import pdsv_pkg::*; #(
  parameter int MaxPoints = MAX_POINTS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire req_t                  req_i,
  output logic                       result_valid_o,
  output res_t                       result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [PCNT_W-1:0] point_count_q;
  logic [THR_W-1:0]  threshold_q;
  cmd_t              front_cmd;
  cmd_t              head;
  logic              q_empty;
  logic              q_full;
  logic              pop;
  logic              accept;
  back_stat_t        back_stat;

  assign busy   = q_full | back_stat.clearing;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= POINT_COUNT_RST;
      threshold_q   <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POINT_COUNT: point_count_q <= cfg_data_i[PCNT_W-1:0];
        REG_THRESHOLD:   threshold_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  pdsv_front #(.MaxPoints(MaxPoints)) u_front (
    .req_i        (req_i),
    .point_count_i(point_count_q),
    .cmd_o        (front_cmd)
  );

  pdsv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_cmd),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  pdsv_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (~q_empty),
    .pop_o         (pop),
    .threshold_i   (threshold_q),
    .stat_o        (back_stat),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

`default_nettype wire

### hdl/pdsv_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module pdsv_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/pdsv_front.sv
// Front end: range and distinctness checks, turns a request into a queue command.
// Depends on pdsv_pkg.
`default_nettype none

module pdsv_front import pdsv_pkg::*; #(
  parameter int MaxPoints = MAX_POINTS
) (
  input  wire req_t              req_i,
  input  wire logic [PCNT_W-1:0] point_count_i,
  output cmd_t                   cmd_o
);

  logic [LIMIT_W-1:0] limit;
  logic [5:0]         bad;
  logic               ab_bad;
  logic               any_bad;
  logic               repeated;

  assign limit = (LIMIT_W'(point_count_i) > LIMIT_W'(MaxPoints)) ?
                 LIMIT_W'(MaxPoints) : LIMIT_W'(point_count_i);

  assign bad[0] = LIMIT_W'(req_i.index_a) >= limit;
  assign bad[1] = LIMIT_W'(req_i.index_b) >= limit;
  assign bad[2] = LIMIT_W'(req_i.index_c) >= limit;
  assign bad[3] = LIMIT_W'(req_i.index_d) >= limit;
  assign bad[4] = LIMIT_W'(req_i.index_e) >= limit;
  assign bad[5] = LIMIT_W'(req_i.index_f) >= limit;

  assign ab_bad  = bad[0] | bad[1];
  assign any_bad = |bad;

  assign repeated = (req_i.index_a == req_i.index_b) || (req_i.index_a == req_i.index_c) ||
                    (req_i.index_a == req_i.index_d) || (req_i.index_b == req_i.index_c) ||
                    (req_i.index_b == req_i.index_d) || (req_i.index_c == req_i.index_d);

  always_comb begin
    cmd_o.a        = req_i.index_a;
    cmd_o.b        = req_i.index_b;
    cmd_o.c        = req_i.index_c;
    cmd_o.d        = req_i.index_d;
    cmd_o.e        = req_i.index_e;
    cmd_o.f        = req_i.index_f;
    cmd_o.distance = req_i.distance_value;
    cmd_o.kind     = KIND_DONE;
    cmd_o.status   = ST_DONE;
    unique case (req_i.opcode)
      OP_LOAD: begin
        if (ab_bad) begin
          cmd_o.status = ST_RANGE;
        end else begin
          cmd_o.kind = KIND_LOAD;
        end
      end
      OP_READ: begin
        if (ab_bad) begin
          cmd_o.status = ST_RANGE;
        end else begin
          cmd_o.kind = KIND_READ;
        end
      end
      OP_VOTE: begin
        if (any_bad) begin
          cmd_o.status = ST_RANGE;
        end else if (repeated) begin
          cmd_o.status = ST_REPEAT;
        end else begin
          cmd_o.kind = KIND_VOTE;
        end
      end
      default: begin
        cmd_o.kind   = KIND_DONE;
        cmd_o.status = ST_DONE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/pdsv_queue.sv
// Short command queue between the front end and the back end.
// Depends on pdsv_pkg.
`default_nettype none

module pdsv_queue import pdsv_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  input  wire logic pop_i,
  output cmd_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("request pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

`default_nettype wire

### hdl/pdsv_back.sv
// Back end: distance and vote memories, vote evaluation, counter updates, results.
// Depends on pdsv_pkg and pdsv_ram.
`default_nettype none

module pdsv_back import pdsv_pkg::*; #(
  parameter int MaxPoints = MAX_POINTS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             head_i,
  input  wire logic             head_valid_i,
  output logic                  pop_o,
  input  wire logic [THR_W-1:0] threshold_i,
  output back_stat_t            stat_o,
  output logic                  result_valid_o,
  output res_t                  result_o
);

  localparam int Cells = MaxPoints * MaxPoints;
  localparam int AddrW = $clog2(Cells);
  localparam int FullW = AddrW + IDX_W;
  localparam logic [AddrW-1:0] ClrLast = AddrW'(Cells - 1);

  // Distance read schedule: two reads per step.
  localparam logic [2:0] StepAbCd = 3'd0;
  localparam logic [2:0] StepAdBc = 3'd1;
  localparam logic [2:0] StepAfBe = 3'd2;
  localparam logic [2:0] StepCfDe = 3'd3;
  localparam logic [2:0] StepEf   = 3'd4;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIST  = 6'b000100,
    S_VWAIT = 6'b001000,
    S_INC_A = 6'b010000,
    S_INC_C = 6'b100000
  } back_state_e;

  function automatic logic [AddrW-1:0] cell_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    logic [FullW-1:0] full;
    full = FullW'(r) * FullW'(MaxPoints) + FullW'(c);
    return full[AddrW-1:0];
  endfunction

  function automatic logic close(logic [DIST_W-1:0] x, logic [DIST_W-1:0] y,
                                 logic [THR_W-1:0] th);
    logic [DIST_W-1:0] diff;
    logic [DIST_W-1:0] neg;
    logic [THR_W-1:0]  mag;
    diff = {1'b0, x[DIST_W-2:0]} - {1'b0, y[DIST_W-2:0]};
    neg  = -diff;
    mag  = diff[DIST_W-1] ? neg[THR_W-1:0] : diff[THR_W-1:0];
    return !x[DIST_W-1] && !y[DIST_W-1] && (mag < th);
  endfunction

  back_state_e       state_q, state_d;
  logic [2:0]        step_q, step_d;
  logic [2:0]        issue_step;
  logic [2:0]        proc_step;
  logic              ok_q, ok_d;
  logic              fin_ok;
  logic [DIST_W-1:0] ab_q, ab_d;
  logic [DIST_W-1:0] cd_q, cd_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic [AddrW-1:0]   addr_ab, addr_cd;
  logic               dram_we;
  logic [AddrW-1:0]   draddr_a, draddr_b;
  logic [DIST_W-1:0]  drdata_a, drdata_b;
  logic               vram_we;
  logic [AddrW-1:0]   vwaddr, vraddr;
  logic [COUNT_W-1:0] vwdata, vrdata, vinc;

  assign addr_ab = cell_addr(head_i.a, head_i.b);
  assign addr_cd = cell_addr(head_i.c, head_i.d);

  pdsv_ram #(.Width(DIST_W), .Depth(Cells)) u_dist_a (
    .clk_i  (clk_i),
    .we_i   (dram_we),
    .waddr_i(addr_ab),
    .wdata_i(head_i.distance),
    .raddr_i(draddr_a),
    .rdata_o(drdata_a)
  );

  pdsv_ram #(.Width(DIST_W), .Depth(Cells)) u_dist_b (
    .clk_i  (clk_i),
    .we_i   (dram_we),
    .waddr_i(addr_ab),
    .wdata_i(head_i.distance),
    .raddr_i(draddr_b),
    .rdata_o(drdata_b)
  );

  pdsv_ram #(.Width(COUNT_W), .Depth(Cells)) u_votes (
    .clk_i  (clk_i),
    .we_i   (vram_we),
    .waddr_i(vwaddr),
    .wdata_i(vwdata),
    .raddr_i(vraddr),
    .rdata_o(vrdata)
  );

  assign issue_step = (state_q == S_IDLE) ? StepAbCd : step_q;
  assign proc_step  = step_q - 3'd1;

  always_comb begin
    case (issue_step)
      StepAbCd: begin
        draddr_a = addr_ab;
        draddr_b = addr_cd;
      end
      StepAdBc: begin
        draddr_a = cell_addr(head_i.a, head_i.d);
        draddr_b = cell_addr(head_i.b, head_i.c);
      end
      StepAfBe: begin
        draddr_a = cell_addr(head_i.a, head_i.f);
        draddr_b = cell_addr(head_i.b, head_i.e);
      end
      StepCfDe: begin
        draddr_a = cell_addr(head_i.c, head_i.f);
        draddr_b = cell_addr(head_i.d, head_i.e);
      end
      default: begin
        draddr_a = cell_addr(head_i.e, head_i.f);
        draddr_b = cell_addr(head_i.e, head_i.f);
      end
    endcase
  end

  // Counter at all-ones stays there.
  assign vinc   = (vrdata == '1) ? vrdata : vrdata + COUNT_W'(1);
  assign vraddr = (state_q == S_INC_A) ? addr_cd : addr_ab;
  assign vwaddr = (state_q == S_CLEAR) ? clr_q :
                  (state_q == S_INC_A) ? addr_ab : addr_cd;
  assign vwdata = (state_q == S_CLEAR) ? '0 : vinc;

  assign fin_ok = ok_q && close(ab_q, drdata_a, threshold_i) &&
                  close(cd_q, drdata_a, threshold_i);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ok_d        = ok_q;
    ab_d        = ab_q;
    cd_d        = cd_q;
    clr_d       = clr_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    dram_we     = 1'b0;
    vram_we     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        vram_we = 1'b1;
        clr_d   = clr_q + AddrW'(1);
        if (clr_q == ClrLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid_i) begin
          unique case (head_i.kind)
            KIND_DONE: begin
              res_valid_d = 1'b1;
              res_d       = '{status: head_i.status, vote_count: '0};
              pop_o       = 1'b1;
            end
            KIND_LOAD: begin
              dram_we     = 1'b1;
              res_valid_d = 1'b1;
              res_d       = '{status: ST_DONE, vote_count: '0};
              pop_o       = 1'b1;
            end
            KIND_READ: begin
              state_d = S_VWAIT;
            end
            default: begin
              state_d = S_DIST;
              step_d  = StepAdBc;
              ok_d    = 1'b1;
            end
          endcase
        end
      end
      S_DIST: begin
        step_d = step_q + 3'd1;
        if (proc_step == StepEf) begin
          if (fin_ok) begin
            state_d = S_INC_A;
          end else begin
            res_valid_d = 1'b1;
            res_d       = '{status: ST_DONE, vote_count: '0};
            pop_o       = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          ok_d = ok_q && close(drdata_a, drdata_b, threshold_i);
          if (proc_step == StepAbCd) begin
            ab_d = drdata_a;
            cd_d = drdata_b;
          end
        end
      end
      S_VWAIT: begin
        res_valid_d = 1'b1;
        res_d       = '{status: ST_DONE, vote_count: vrdata};
        pop_o       = 1'b1;
        state_d     = S_IDLE;
      end
      S_INC_A: begin
        vram_we = 1'b1;
        state_d = S_INC_C;
      end
      S_INC_C: begin
        vram_we     = 1'b1;
        res_valid_d = 1'b1;
        res_d       = '{status: ST_VOTED, vote_count: '0};
        pop_o       = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= StepAbCd;
      ok_q        <= 1'b0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ok_q        <= ok_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ab_q  <= ab_d;
    cd_q  <= cd_d;
    res_q <= res_d;
  end

  assign stat_o.clearing = (state_q == S_CLEAR);
  assign result_valid_o  = res_valid_q;
  assign result_o        = res_q;

  a_no_result_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !res_valid_q)
    else $error("result strobe right after a clearing cycle");

  a_voted_after_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.status == ST_VOTED)) |-> ($past(state_q) == S_INC_C))
    else $error("voted status without a counter update");

  a_pop_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> res_valid_q)
    else $error("request retired without a result");

endmodule

`default_nettype wire
